/* rtl/core/coef_table_log_interpolator_macros.svh */
// assertion macros for the coefficient table datapath
`ifndef COEF_TABLE_LOG_INTERPOLATOR_MACROS_SVH
`define COEF_TABLE_LOG_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define CTIL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CTIL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ctil_pkg.sv */
// package: sizes, codes and controller/datapath interface types
package ctil_pkg;

	localparam int TABLE_ENTRIES   = 64;
	localparam int COEFS_PER_ENTRY = 15;
	localparam int IDX_W           = $clog2(TABLE_ENTRIES);
	localparam int COEF_DEPTH      = TABLE_ENTRIES * COEFS_PER_ENTRY;
	localparam int COEF_AW         = $clog2(COEF_DEPTH);
	localparam int K_W             = 4;
	localparam int HDR_W           = 40;
	localparam int LOG_FRAC        = 24;
	localparam int LOG_W           = 28;
	localparam int T_W             = 17;
	localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1) > 5 ? $clog2(TABLE_ENTRIES + 1) : 5;
	localparam int DIV_STEPS       = 17;

	localparam logic [1:0] OP_HEADER     = 2'd0;
	localparam logic [1:0] OP_COEF       = 2'd1;
	localparam logic [1:0] OP_LOOKUP     = 2'd2;
	localparam logic [1:0] OP_INVALIDATE = 2'd3;

	localparam logic [1:0] HOW_EXACT  = 2'd0;
	localparam logic [1:0] HOW_CLAMP  = 2'd1;
	localparam logic [1:0] HOW_INTERP = 2'd2;

	localparam logic [1:0] LOG_Q = 2'd0;
	localparam logic [1:0] LOG_L = 2'd1;
	localparam logic [1:0] LOG_H = 2'd2;

	typedef struct packed {
		logic             load;
		logic             clear;
		logic             scan_rd;
		logic [IDX_W-1:0] scan_addr;
		logic             decide;
		logic             out_none;
		logic             log_go;
		logic [1:0]       log_sel;
		logic             div_init;
		logic             div_step;
		logic             rd_lo;
		logic             rd_hi;
		logic             mul;
		logic             out_coef;
		logic [K_W-1:0]   k;
	} cmd_t;

	typedef struct packed {
		logic any;
		logic direct;
		logic log_done;
	} status_t;

endpackage

/* rtl/core/ctil_ram.sv */
// generic single write port ram with registered read
module ctil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ctil_log2.sv */
// iterative log2 unit, unsigned q4.24 result, one squaring step per cycle
module ctil_log2 (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [15:0]              x,
	output logic                     done,
	output logic [ctil_pkg::LOG_W-1:0] result
);

	logic [31:0] m_q;
	logic [ctil_pkg::LOG_FRAC-1:0] frac_q;
	logic [3:0]  n_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [15:0] xx;
	logic [3:0]  n_c;
	logic [63:0] prod;
	logic [32:0] sh;

	always_comb begin
		xx = (x == 16'd0) ? 16'd1 : x;
		n_c = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (xx[i]) begin
				n_c = 4'(i);
			end
		end
		prod = 64'(m_q) * 64'(m_q);
		sh = prod[63:31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ctil_pkg::LOG_FRAC - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q    <= n_c;
			m_q    <= 32'(xx) << (5'd31 - 5'(n_c));
			frac_q <= '0;
		end else if (run_q) begin
			// squared mantissa at or above two gives a one bit
			if (sh[32]) begin
				m_q    <= sh[32:1];
				frac_q <= {frac_q[ctil_pkg::LOG_FRAC-2:0], 1'b1};
			end else begin
				m_q    <= sh[31:0];
				frac_q <= {frac_q[ctil_pkg::LOG_FRAC-2:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = {n_q, frac_q};

endmodule

/* rtl/core/ctil_ctrl.sv */
// controller state machine: scan, decide, log, divide and coefficient sequencing
module ctil_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  ctil_pkg::status_t  st,
	output logic               busy,
	output ctil_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_LOGQ   = 3'd3;
	localparam logic [2:0] ST_LOGL   = 3'd4;
	localparam logic [2:0] ST_LOGH   = 3'd5;
	localparam logic [2:0] ST_DIV    = 3'd6;
	localparam logic [2:0] ST_COEF   = 3'd7;

	logic [2:0]                     state_q, state_d;
	logic [ctil_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [ctil_pkg::K_W-1:0]       k_q, k_d;
	logic [1:0]                     step_q, step_d;
	logic                           accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		step_d  = step_q;
		cmd     = '0;
		cmd.k   = k_q;
		cmd.scan_addr = cnt_q[ctil_pkg::IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == ctil_pkg::OP_LOOKUP) begin
						cmd.clear = 1'b1;
						cnt_d     = '0;
						state_d   = ST_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (cnt_q < ctil_pkg::CNT_W'(ctil_pkg::TABLE_ENTRIES)) begin
					cmd.scan_rd = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				cnt_d  = '0;
				k_d    = '0;
				step_d = '0;
				if (!st.any) begin
					cmd.out_none = 1'b1;
					state_d = ST_IDLE;
				end else if (st.direct) begin
					state_d = ST_COEF;
				end else begin
					state_d = ST_LOGQ;
				end
			end
			ST_LOGQ, ST_LOGL, ST_LOGH: begin
				unique case (state_q)
					ST_LOGQ: cmd.log_sel = ctil_pkg::LOG_Q;
					ST_LOGL: cmd.log_sel = ctil_pkg::LOG_L;
					default: cmd.log_sel = ctil_pkg::LOG_H;
				endcase
				if (cnt_q == '0) begin
					cmd.log_go = 1'b1;
					cnt_d = ctil_pkg::CNT_W'(1);
				end
				if (st.log_done) begin
					cnt_d = '0;
					unique case (state_q)
						ST_LOGQ: state_d = ST_LOGL;
						ST_LOGL: state_d = ST_LOGH;
						default: state_d = ST_DIV;
					endcase
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					cmd.div_init = 1'b1;
				end else begin
					cmd.div_step = 1'b1;
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == ctil_pkg::CNT_W'(ctil_pkg::DIV_STEPS)) begin
					step_d  = '0;
					k_d     = '0;
					state_d = ST_COEF;
				end
			end
			ST_COEF: begin
				step_d = step_q + 2'd1;
				unique case (step_q)
					2'd0: cmd.rd_lo = 1'b1;
					2'd1: cmd.rd_hi = 1'b1;
					2'd2: cmd.mul   = 1'b1;
					default: begin
						cmd.out_coef = 1'b1;
						if (k_q == ctil_pkg::K_W'(ctil_pkg::COEFS_PER_ENTRY - 1)) begin
							state_d = ST_IDLE;
						end else begin
							k_d = k_q + 1'b1;
						end
					end
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			step_q  <= step_d;
		end
	end

endmodule

/* rtl/core/ctil_dp.sv */
// datapath: table storage, scan registers, log and divide, interpolation and result
`include "coef_table_log_interpolator_macros.svh"

module ctil_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ctil_pkg::cmd_t    cmd,
	output ctil_pkg::status_t st,
	input  logic [1:0]        opcode,
	input  logic [5:0]        entry_index,
	input  logic [15:0]       unit_id,
	input  logic [7:0]        channel,
	input  logic [15:0]       cutoff_hz,
	input  logic [3:0]        coef_slot,
	input  logic signed [31:0] coef_in,
	output logic              valid,
	output logic              found,
	output logic [1:0]        how,
	output logic [3:0]        coef_index,
	output logic signed [31:0] coef_out,
	output logic              last
);

	localparam int IW = ctil_pkg::IDX_W;
	localparam int AW = ctil_pkg::COEF_AW;
	localparam int LW = ctil_pkg::LOG_W;

	// table storage
	logic [ctil_pkg::TABLE_ENTRIES-1:0] vld_q;
	logic                  idx_ok;
	logic [IW-1:0]         widx;
	logic                  hdr_we, coef_we;
	logic [ctil_pkg::HDR_W-1:0] hdr_rdata;
	logic [AW-1:0]         coef_waddr, coef_raddr;
	logic signed [31:0]    coef_rdata;

	// query and scan
	logic [15:0]   q_unit_q;
	logic [7:0]    q_ch_q;
	logic [15:0]   q_cut_q;
	logic          scan_s1;
	logic [IW-1:0] idx_s1;
	logic          match;
	logic [15:0]   c;
	logic          ex_v_q, lo_v_q, hi_v_q, bl_v_q, ab_v_q;
	logic [IW-1:0] ex_i_q, lo_i_q, hi_i_q, bl_i_q, ab_i_q;
	logic [15:0]   lo_c_q, hi_c_q, bl_c_q, ab_c_q;

	// selection, log and divide
	logic [IW-1:0] sel_lo_q, sel_hi_q;
	logic [1:0]    how_q;
	logic          log_done;
	logic [LW-1:0] log_res;
	logic [15:0]   log_x;
	logic [LW-1:0] lq_q, ll_q, lh_q;
	logic [LW-1:0] dvs;
	logic [LW:0]   rem_q, rem_sub;
	logic          rem_ge;
	logic          dz_q;
	logic [ctil_pkg::T_W-1:0] t_q;

	// interpolation
	logic signed [31:0] a_lo_q;
	logic signed [49:0] p_lo_q, p_hi_q;
	logic signed [50:0] sum;
	logic [ctil_pkg::T_W-1:0] w_lo;
	logic [IW-1:0] rd_slot;

	// result
	logic          valid_q, found_q, last_q;
	logic [1:0]    how_o_q;
	logic [3:0]    kidx_q;
	logic signed [31:0] coef_o_q;

	assign idx_ok  = (32'(entry_index) < ctil_pkg::TABLE_ENTRIES);
	assign widx    = IW'(entry_index);
	assign hdr_we  = cmd.load && idx_ok && (opcode == ctil_pkg::OP_HEADER);
	assign coef_we = cmd.load && idx_ok && (opcode == ctil_pkg::OP_COEF)
		&& (32'(coef_slot) < ctil_pkg::COEFS_PER_ENTRY);
	assign coef_waddr = AW'(widx) * AW'(ctil_pkg::COEFS_PER_ENTRY) + AW'(coef_slot);
	assign rd_slot    = cmd.rd_hi ? sel_hi_q : sel_lo_q;
	assign coef_raddr = AW'(rd_slot) * AW'(ctil_pkg::COEFS_PER_ENTRY) + AW'(cmd.k);

	ctil_ram #(.WIDTH(ctil_pkg::HDR_W), .DEPTH(ctil_pkg::TABLE_ENTRIES)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (widx),
		.wdata ({unit_id, channel, cutoff_hz}),
		.raddr (cmd.scan_addr),
		.rdata (hdr_rdata)
	);

	ctil_ram #(.WIDTH(32), .DEPTH(ctil_pkg::COEF_DEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_in),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			if (cmd.load && idx_ok) begin
				if (opcode == ctil_pkg::OP_HEADER) begin
					vld_q[widx] <= 1'b1;
				end else if (opcode == ctil_pkg::OP_INVALIDATE) begin
					vld_q[widx] <= 1'b0;
				end
			end
		end
	end

	assign c     = hdr_rdata[15:0];
	assign match = scan_s1 && vld_q[idx_s1] && (hdr_rdata[39:24] == q_unit_q)
		&& (hdr_rdata[23:16] == q_ch_q);

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.scan_addr;
		if (cmd.clear) begin
			q_unit_q <= unit_id;
			q_ch_q   <= channel;
			q_cut_q  <= cutoff_hz;
			ex_v_q <= 1'b0;
			lo_v_q <= 1'b0;
			hi_v_q <= 1'b0;
			bl_v_q <= 1'b0;
			ab_v_q <= 1'b0;
		end else if (match) begin
			if (c == q_cut_q && !ex_v_q) begin
				ex_v_q <= 1'b1;
				ex_i_q <= idx_s1;
			end
			if (!lo_v_q || c < lo_c_q) begin
				lo_v_q <= 1'b1;
				lo_i_q <= idx_s1;
				lo_c_q <= c;
			end
			if (!hi_v_q || c > hi_c_q) begin
				hi_v_q <= 1'b1;
				hi_i_q <= idx_s1;
				hi_c_q <= c;
			end
			if (c < q_cut_q && (!bl_v_q || c > bl_c_q)) begin
				bl_v_q <= 1'b1;
				bl_i_q <= idx_s1;
				bl_c_q <= c;
			end
			if (c > q_cut_q && (!ab_v_q || c < ab_c_q)) begin
				ab_v_q <= 1'b1;
				ab_i_q <= idx_s1;
				ab_c_q <= c;
			end
		end
	end

	assign st.any      = lo_v_q;
	assign st.direct   = ex_v_q || !bl_v_q || !ab_v_q;
	assign st.log_done = log_done;

	always_comb begin
		unique case (cmd.log_sel)
			ctil_pkg::LOG_L: log_x = bl_c_q;
			ctil_pkg::LOG_H: log_x = ab_c_q;
			default:         log_x = q_cut_q;
		endcase
	end

	ctil_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.log_go),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	assign dvs     = lh_q - ll_q;
	assign rem_ge  = (rem_q >= {1'b0, dvs});
	assign rem_sub = rem_ge ? (rem_q - {1'b0, dvs}) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			t_q <= '0;
			// a single slot is emitted with lo and hi on the same slot and zero weight
			if (ex_v_q) begin
				sel_lo_q <= ex_i_q;
				sel_hi_q <= ex_i_q;
				how_q    <= ctil_pkg::HOW_EXACT;
			end else if (!bl_v_q) begin
				sel_lo_q <= lo_i_q;
				sel_hi_q <= lo_i_q;
				how_q    <= ctil_pkg::HOW_CLAMP;
			end else if (!ab_v_q) begin
				sel_lo_q <= hi_i_q;
				sel_hi_q <= hi_i_q;
				how_q    <= ctil_pkg::HOW_CLAMP;
			end else begin
				sel_lo_q <= bl_i_q;
				sel_hi_q <= ab_i_q;
				how_q    <= ctil_pkg::HOW_INTERP;
			end
		end
		if (log_done) begin
			unique case (cmd.log_sel)
				ctil_pkg::LOG_L: ll_q <= log_res;
				ctil_pkg::LOG_H: lh_q <= log_res;
				default:         lq_q <= log_res;
			endcase
		end
		if (cmd.div_init) begin
			t_q   <= '0;
			rem_q <= {1'b0, lq_q - ll_q};
			dz_q  <= !((lh_q > ll_q) && (lq_q >= ll_q));
		end else if (cmd.div_step && !dz_q) begin
			t_q   <= {t_q[ctil_pkg::T_W-2:0], rem_ge};
			rem_q <= {rem_sub[LW-1:0], 1'b0};
		end
	end

	assign w_lo = ctil_pkg::T_W'(65536) - t_q;
	assign sum  = 51'(p_lo_q) + 51'(p_hi_q) + 51'sd32768;

	always_ff @(posedge clk) begin
		if (cmd.rd_hi) begin
			a_lo_q <= coef_rdata;
		end
		if (cmd.mul) begin
			p_lo_q <= a_lo_q * $signed({1'b0, w_lo});
			p_hi_q <= coef_rdata * $signed({1'b0, t_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.out_none || cmd.out_coef;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_none) begin
			found_q  <= 1'b0;
			how_o_q  <= ctil_pkg::HOW_EXACT;
			kidx_q   <= '0;
			coef_o_q <= '0;
			last_q   <= 1'b1;
		end else if (cmd.out_coef) begin
			found_q  <= 1'b1;
			how_o_q  <= how_q;
			kidx_q   <= cmd.k;
			// floor of the rounded q16 product sum
			coef_o_q <= sum[47:16];
			last_q   <= (cmd.k == ctil_pkg::K_W'(ctil_pkg::COEFS_PER_ENTRY - 1));
		end
	end

	assign valid      = valid_q;
	assign found      = found_q;
	assign how        = how_o_q;
	assign coef_index = kidx_q;
	assign coef_out   = coef_o_q;
	assign last       = last_q;

	`CTIL_ASSERT_NOW(a_none_is_last, valid_q && !found_q, last_q, "not-found result without last")
	`CTIL_ASSERT_NOW(a_last_index, valid_q && found_q && last_q,
		kidx_q == ctil_pkg::K_W'(ctil_pkg::COEFS_PER_ENTRY - 1), "last on wrong coefficient")
	`CTIL_ASSERT_NEXT(a_weight_range, cmd.div_step, t_q <= ctil_pkg::T_W'(65536),
		"interpolation weight above one")

endmodule

/* rtl/core/coef_table_log_interpolator.sv */
// top level: coefficient table with log-frequency interpolation
// A load transaction (write header, write coefficient, invalidate) is taken in the idle state,
// never raises busy and gives no result. A lookup reads the 64 headers one per cycle from the
// header ram, decides, and then emits 15 results in turn, each set by the two reads of the
// single coefficient ram port, the multiply and the output register. For an interpolated lookup,
// three 24-step log2 evaluations on one shared squaring unit and a bit-serial divide come between
// the decision and the results. A lookup with no match gives a single result. busy is high while
// the lookup runs and falls as its last result is registered; each result is shown for one cycle
// on valid and cannot be held off.
module coef_table_log_interpolator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [5:0]         entry_index,
	input  logic [15:0]        unit_id,
	input  logic [7:0]         channel,
	input  logic [15:0]        cutoff_hz,
	input  logic [3:0]         coef_slot,
	input  logic signed [31:0] coef_in,
	output logic               valid,
	output logic               found,
	output logic [1:0]         how,
	output logic [3:0]         coef_index,
	output logic signed [31:0] coef_out,
	output logic               last
);

	ctil_pkg::cmd_t    cmd;
	ctil_pkg::status_t st;

	ctil_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	ctil_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.opcode      (opcode),
		.entry_index (entry_index),
		.unit_id     (unit_id),
		.channel     (channel),
		.cutoff_hz   (cutoff_hz),
		.coef_slot   (coef_slot),
		.coef_in     (coef_in),
		.valid       (valid),
		.found       (found),
		.how         (how),
		.coef_index  (coef_index),
		.coef_out    (coef_out),
		.last        (last)
	);

endmodule

/* sim/coef_table_checker.sv */
// checker: watches the command and result channels, predicts lookups and compares
`timescale 1ns / 1ps
module coef_table_checker
	import ctil_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         opcode,
	input  logic [5:0]         entry_index,
	input  logic [15:0]        unit_id,
	input  logic [7:0]         channel,
	input  logic [15:0]        cutoff_hz,
	input  logic [3:0]         coef_slot,
	input  logic signed [31:0] coef_in,
	input  logic               valid,
	input  logic               found,
	input  logic [1:0]         how,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_out,
	input  logic               last,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic        found;
		logic [1:0]  how;
		logic [3:0]  index;
		logic [31:0] coef;
		logic        last;
	} coef_res_t;

	coef_res_t   coef_expected_q[$];
	logic        slot_valid[TABLE_ENTRIES];
	logic [15:0] slot_unit[TABLE_ENTRIES];
	logic [7:0]  slot_channel[TABLE_ENTRIES];
	logic [15:0] slot_cutoff[TABLE_ENTRIES];
	logic [31:0] slot_coef[TABLE_ENTRIES][COEFS_PER_ENTRY];

	// log2 in unsigned q4.24, mantissa squared 24 times
	function automatic logic [27:0] log2_q24(input logic [15:0] x);
		logic [15:0] xx;
		logic [3:0]  n;
		logic [63:0] m;
		logic [23:0] frac;
		xx = (x == 0) ? 16'd1 : x;
		n = 0;
		frac = 0;
		for (int i = 0; i < 16; i++)
			if ((xx >> i) != 0) n = i;
		m = 64'(xx) << (31 - n);
		for (int k = 0; k < 24; k++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return {n, frac};
	endfunction

	task automatic predict_lookup(input logic [15:0] unit, input logic [7:0] ch,
			input logic [15:0] q);
		int exact, lo_end, hi_end, below, above, s;
		logic [27:0] ll, lh, lq;
		longint t, r;
		coef_res_t res;
		exact = -1; lo_end = -1; hi_end = -1; below = -1; above = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (slot_valid[i] && slot_unit[i] == unit && slot_channel[i] == ch) begin
				if (slot_cutoff[i] == q && exact < 0) exact = i;
				if (lo_end < 0 || slot_cutoff[i] < slot_cutoff[lo_end]) lo_end = i;
				if (hi_end < 0 || slot_cutoff[i] > slot_cutoff[hi_end]) hi_end = i;
				if (slot_cutoff[i] < q && (below < 0 || slot_cutoff[i] > slot_cutoff[below]))
					below = i;
				if (slot_cutoff[i] > q && (above < 0 || slot_cutoff[i] < slot_cutoff[above]))
					above = i;
			end
		end
		if (lo_end < 0) begin
			res = '{found: 1'b0, how: HOW_EXACT, index: 4'd0, coef: 32'd0, last: 1'b1};
			coef_expected_q.push_back(res);
		end else if (exact >= 0 || below < 0 || above < 0) begin
			s = exact >= 0 ? exact : (below < 0 ? lo_end : hi_end);
			for (int k = 0; k < COEFS_PER_ENTRY; k++) begin
				res.found = 1'b1;
				res.how = exact >= 0 ? HOW_EXACT : HOW_CLAMP;
				res.index = 4'(k);
				res.coef = slot_coef[s][k];
				res.last = (k == COEFS_PER_ENTRY - 1);
				coef_expected_q.push_back(res);
			end
		end else begin
			ll = log2_q24(slot_cutoff[below]);
			lh = log2_q24(slot_cutoff[above]);
			lq = log2_q24(q);
			t = 0;
			if (lh > ll && lq >= ll) begin
				t = (longint'(lq - ll) << 16) / longint'(lh - ll);
				if (t > 65536) t = 65536;
			end
			for (int k = 0; k < COEFS_PER_ENTRY; k++) begin
				r = longint'($signed(slot_coef[below][k])) * (65536 - t)
					+ longint'($signed(slot_coef[above][k])) * t;
				r = (r + 32768) >>> 16;
				res.found = 1'b1;
				res.how = HOW_INTERP;
				res.index = 4'(k);
				res.coef = r[31:0];
				res.last = (k == COEFS_PER_ENTRY - 1);
				coef_expected_q.push_back(res);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		coef_res_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
			coef_expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (valid) begin
				got = '{found: found, how: how, index: coef_index, coef: coef_out, last: last};
				if (coef_expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: found %0d how %0d index %0d coef %h last %0d",
							found, how, coef_index, coef_out, last);
				end else begin
					want = coef_expected_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("expected found %0d how %0d index %0d coef %h last %0d, got found %0d how %0d index %0d coef %h last %0d",
								want.found, want.how, want.index, want.coef, want.last,
								got.found, got.how, got.index, got.coef, got.last);
					end
				end
			end
			if (start && !busy) begin
				case (opcode)
					OP_HEADER: begin
						slot_valid[entry_index] = 1'b1;
						slot_unit[entry_index] = unit_id;
						slot_channel[entry_index] = channel;
						slot_cutoff[entry_index] = cutoff_hz;
					end
					OP_COEF: begin
						if (coef_slot < COEFS_PER_ENTRY)
							slot_coef[entry_index][coef_slot] = coef_in;
					end
					OP_LOOKUP: predict_lookup(unit_id, channel, cutoff_hz);
					default: slot_valid[entry_index] = 1'b0;
				endcase
			end
			pending = coef_expected_q.size();
		end
	end

endmodule

/* sim/tb.sv */
// testbench top: drives load and lookup transactions and gives the verdict
`timescale 1ns / 1ps
module tb;
	import ctil_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = OP_HEADER;
	logic [5:0]         entry_index = '0;
	logic [15:0]        unit_id = '0;
	logic [7:0]         channel = '0;
	logic [15:0]        cutoff_hz = '0;
	logic [3:0]         coef_slot = '0;
	logic signed [31:0] coef_in = '0;
	logic               valid, found, last;
	logic [1:0]         how;
	logic [3:0]         coef_index;
	logic signed [31:0] coef_out;
	int                 errors, pending;
	int                 cycles = 0;
	int                 sent = 0;
	logic [COEFS_PER_ENTRY-1:0] coefs_written[TABLE_ENTRIES];
	logic [15:0]        unit_pool[4] = '{16'hFFFF, 16'h0000, 16'h1234, 16'h00A5};
	logic [7:0]         chan_pool[3] = '{8'hFF, 8'h00, 8'h07};

	always #1 clk = ~clk;

	coef_table_log_interpolator uut (.*);

	coef_table_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("coef_table_log_interpolator: mismatch");
			$finish;
		end
	end

	// one transaction; start stays high into the next one when there is no gap
	task automatic send(input logic [1:0] op, input logic [5:0] idx, input logic [15:0] unit,
			input logic [7:0] ch, input logic [15:0] cut, input logic [3:0] slot,
			input logic [31:0] value);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		unit_id <= unit;
		channel <= ch;
		cutoff_hz <= cut;
		coef_slot <= slot;
		coef_in <= value;
		sent++;
		if (op == OP_COEF && slot < COEFS_PER_ENTRY) coefs_written[idx][slot] = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic fill_slot(input logic [5:0] idx, input logic [31:0] a, input logic [31:0] b);
		for (int k = 0; k < COEFS_PER_ENTRY; k++)
			send(OP_COEF, idx, $urandom, $urandom, $urandom, 4'(k), (k % 2) ? a : b);
	endtask

	initial begin
		logic [5:0] idx;
		int sel;
		logic paused;
		paused = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) coefs_written[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme coefficients, every opcode, clamps, exact, zero query
		fill_slot(6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		fill_slot(6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
		fill_slot(6'd1, 32'h0001_0000, 32'hFFFF_0000);
		send(OP_COEF, 6'd1, 0, 0, 0, 4'd15, 32'hDEAD_BEEF);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd100, 0, 0);
		send(OP_HEADER, 6'd0, 16'hFFFF, 8'hFF, 16'd100, 0, 0);
		send(OP_HEADER, 6'd63, 16'hFFFF, 8'hFF, 16'd65535, 0, 0);
		send(OP_HEADER, 6'd1, 16'hFFFF, 8'hFF, 16'd65533, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd100, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd0, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd65535, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd1000, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd65534, 0, 0);
		send(OP_LOOKUP, 0, 16'h0000, 8'h00, 16'd1000, 0, 0);
		send(OP_HEADER, 6'd1, 16'hFFFF, 8'hFF, 16'd0, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd50, 0, 0);
		send(OP_INVALIDATE, 6'd63, 0, 0, 0, 0, 0);
		send(OP_LOOKUP, 0, 16'hFFFF, 8'hFF, 16'd65535, 0, 0);

		// random: mostly table building and matching lookups on a few keys
		while (sent < 130) begin
			if (!paused && sent >= 65) begin
				paused = 1'b1;
				start <= 1'b0;
				do @(posedge clk); while (pending != 0 || busy);
			end
			idx = $urandom;
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				if (sel < 3)
					send(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				else
					send(OP_LOOKUP, $urandom, unit_pool[$urandom_range(0, 3)],
						chan_pool[$urandom_range(0, 2)],
						(sel < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom), $urandom,
						$urandom);
			end else if (sel < 55 && &coefs_written[idx]) begin
				send(OP_HEADER, idx, unit_pool[$urandom_range(0, 3)],
					chan_pool[$urandom_range(0, 2)],
					(sel < 35) ? 16'($urandom_range(0, 2)) : 16'($urandom), $urandom, $urandom);
			end else if (sel < 60) begin
				send(OP_INVALIDATE, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				for (int k = 0; k < COEFS_PER_ENTRY; k++)
					if (!coefs_written[idx][k])
						send(OP_COEF, idx, $urandom, $urandom, $urandom, 4'(k), $urandom);
				send(OP_COEF, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
		start <= 1'b0;

		do @(posedge clk); while (pending != 0 || busy);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("coef_table_log_interpolator: match");
		else
			$display("coef_table_log_interpolator: mismatch");
		$finish;
	end

endmodule
